@@ rtl/core/mfq_pkg.sv @@
// shared types, constants and helpers for the multilevel feedback queue scheduler
`timescale 1ns / 1ps

package mfq_pkg;

   localparam int NUM_LEVELS  = 11;
   localparam int LEVEL_DEPTH = 16;
   localparam int ID_BITS     = 8;

   localparam int LEVEL_BITS = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SLOT_BITS  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(LEVEL_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_BITS  = $clog2(STORE_DEPTH);

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [ID_BITS-1:0]    id_type;

   localparam level_type LAST_LEVEL       = level_type'(NUM_LEVELS - 1);
   localparam logic [3:0] LAST_LEVEL_FIELD = 4'(NUM_LEVELS - 1);
   localparam slot_type  LAST_SLOT        = slot_type'(LEVEL_DEPTH - 1);
   localparam count_type LEVEL_FULL       = count_type'(LEVEL_DEPTH);
   localparam logic [15:0] QUANTUM_RESET  = 16'd2;

   // item kinds
   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [2:0] STATUS_DROPPED   = 3'd1;
   localparam logic [2:0] STATUS_IDLE      = 3'd2;
   localparam logic [2:0] STATUS_PREEMPTED = 3'd3;
   localparam logic [2:0] STATUS_FINISHED  = 3'd4;

   typedef struct packed {
      logic        kind;
      logic [7:0]  task_id;
      logic [3:0]  start_level;
      logic [15:0] run_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_task_id;
      logic [3:0]  out_level;
      logic [15:0] slice;
      logic        first_run;
      logic        requeue_lost;
   } rsp_type;

   typedef struct packed {
      id_type      id;
      logic [15:0] remaining;
      logic        started;
   } task_type;

   localparam int TASK_BITS = $bits(task_type);

   // controller to datapath
   typedef struct packed {
      logic arrival;
      logic demote;
      logic pick;
      logic grant;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic found;
   } dp_status_type;

   function automatic slot_type next_slot(input slot_type s);
      next_slot = (s == LAST_SLOT) ? '0 : slot_type'(s + 1'b1);
   endfunction

   function automatic addr_type slot_addr(input level_type lvl, input slot_type s);
      slot_addr = addr_type'(int'(lvl) * LEVEL_DEPTH + int'(s));
   endfunction

endpackage

@@ rtl/core/mfq_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module mfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mfq_ctrl.sv @@
// sequencing state machine for the scheduler
`timescale 1ns / 1ps

module mfq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_kind,
   input  mfq_pkg::dp_status_type dp_status,
   output mfq_pkg::ctl_cmd_type  cmd,
   output logic                  busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_GRANT
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_comb begin
      cmd         = '0;
      cmd.arrival = (state_ff == ST_IDLE) && start && (req_kind == mfq_pkg::KIND_ARRIVAL);
      cmd.demote  = (state_ff == ST_IDLE) && start && (req_kind == mfq_pkg::KIND_TICK);
      cmd.pick    = (state_ff == ST_PICK);
      cmd.grant   = (state_ff == ST_GRANT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start && (req_kind == mfq_pkg::KIND_TICK)) begin
                  state_ff <= ST_PICK;
                  busy_ff  <= 1'b1;
               end
            end
            ST_PICK: begin
               if (dp_status.found) begin
                  state_ff <= ST_GRANT;
               end else begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_GRANT: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

@@ rtl/core/mfq_dp.sv @@
// level pointers, held task, quantum register and result register
`timescale 1ns / 1ps

module mfq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  mfq_pkg::ctl_cmd_type   cmd,
   input  mfq_pkg::req_type       req_item,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   output mfq_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   output mfq_pkg::rsp_type       rsp_item
);

   mfq_pkg::slot_type  head_ff  [mfq_pkg::NUM_LEVELS];
   mfq_pkg::slot_type  tail_ff  [mfq_pkg::NUM_LEVELS];
   mfq_pkg::count_type count_ff [mfq_pkg::NUM_LEVELS];

   logic                held_valid_ff;
   mfq_pkg::task_type   held_task_ff;
   mfq_pkg::level_type  held_level_ff;
   mfq_pkg::level_type  pick_level_ff;
   logic                lost_ff;
   logic [15:0]         quantum_ff;
   logic                rsp_valid_ff;
   mfq_pkg::rsp_type    rsp_ff;

   logic                held_valid_in;
   mfq_pkg::task_type   held_task_in;
   mfq_pkg::level_type  held_level_in;
   logic                rsp_valid_in;
   mfq_pkg::rsp_type    rsp_in;

   mfq_pkg::level_type  arr_level;
   mfq_pkg::level_type  demote_level;
   mfq_pkg::level_type  pick_level;
   logic                found;
   mfq_pkg::level_type  sel_level;
   logic                has_room;
   logic                push_en;
   logic                pop_en;
   mfq_pkg::task_type   wr_task;
   mfq_pkg::addr_type   wr_addr;
   mfq_pkg::addr_type   rd_addr;
   logic [mfq_pkg::TASK_BITS-1:0] rd_data;
   mfq_pkg::task_type   rd_task;

   always_comb begin
      arr_level = (req_item.start_level > mfq_pkg::LAST_LEVEL_FIELD) ?
                  mfq_pkg::LAST_LEVEL : mfq_pkg::level_type'(req_item.start_level);
      demote_level = (held_level_ff == mfq_pkg::LAST_LEVEL) ?
                     mfq_pkg::LAST_LEVEL : mfq_pkg::level_type'(held_level_ff + 1'b1);

      // lowest-numbered nonempty level wins
      found      = 1'b0;
      pick_level = '0;
      for (int i = mfq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            found      = 1'b1;
            pick_level = mfq_pkg::level_type'(i);
         end
      end

      if (cmd.arrival) begin
         sel_level = arr_level;
      end else if (cmd.demote) begin
         sel_level = demote_level;
      end else begin
         sel_level = pick_level;
      end

      has_room = (count_ff[sel_level] != mfq_pkg::LEVEL_FULL);
      push_en  = (cmd.arrival || (cmd.demote && held_valid_ff)) && has_room;
      pop_en   = cmd.pick && found;

      if (cmd.arrival) begin
         wr_task.id        = mfq_pkg::id_type'(req_item.task_id);
         wr_task.remaining = req_item.run_time;
         wr_task.started   = 1'b0;
      end else begin
         wr_task = held_task_ff;
      end

      wr_addr = mfq_pkg::slot_addr(sel_level, tail_ff[sel_level]);
      rd_addr = mfq_pkg::slot_addr(sel_level, head_ff[sel_level]);
      rd_task = mfq_pkg::task_type'(rd_data);
   end

   // result and held task next values
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      held_valid_in = held_valid_ff;
      held_task_in  = held_task_ff;
      held_level_in = held_level_ff;

      if (cmd.arrival) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = has_room ? mfq_pkg::STATUS_ACCEPTED : mfq_pkg::STATUS_DROPPED;
      end

      if (cmd.demote) begin
         held_valid_in = 1'b0;
      end

      if (cmd.pick && !found) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = '0;
         rsp_in.status       = mfq_pkg::STATUS_IDLE;
         rsp_in.requeue_lost = lost_ff;
      end

      if (cmd.grant) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = '0;
         rsp_in.out_task_id  = 8'(rd_task.id);
         rsp_in.out_level    = 4'(pick_level_ff);
         rsp_in.first_run    = !rd_task.started;
         rsp_in.requeue_lost = lost_ff;
         if (rd_task.remaining > quantum_ff) begin
            rsp_in.status          = mfq_pkg::STATUS_PREEMPTED;
            rsp_in.slice           = quantum_ff;
            held_valid_in          = 1'b1;
            held_level_in          = pick_level_ff;
            held_task_in.id        = rd_task.id;
            held_task_in.remaining = rd_task.remaining - quantum_ff;
            held_task_in.started   = 1'b1;
         end else begin
            rsp_in.status = mfq_pkg::STATUS_FINISHED;
            rsp_in.slice  = rd_task.remaining;
         end
      end
   end

   mfq_ram #(
      .WIDTH(mfq_pkg::TASK_BITS),
      .DEPTH(mfq_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (push_en),
      .wr_addr(wr_addr),
      .wr_data(wr_task),
      .rd_en  (pop_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mfq_pkg::NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         held_valid_ff <= 1'b0;
         held_task_ff  <= '0;
         held_level_ff <= '0;
         quantum_ff    <= mfq_pkg::QUANTUM_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ff        <= rsp_in;
         held_valid_ff <= held_valid_in;
         held_task_ff  <= held_task_in;
         held_level_ff <= held_level_in;

         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end

         for (int i = 0; i < mfq_pkg::NUM_LEVELS; i++) begin
            if (mfq_pkg::level_type'(i) == sel_level) begin
               if (push_en) begin
                  tail_ff[i]  <= mfq_pkg::next_slot(tail_ff[i]);
                  count_ff[i] <= mfq_pkg::count_type'(count_ff[i] + 1'b1);
               end else if (pop_en) begin
                  head_ff[i]  <= mfq_pkg::next_slot(head_ff[i]);
                  count_ff[i] <= mfq_pkg::count_type'(count_ff[i] - 1'b1);
               end
            end
         end

         if (cmd.demote) begin
            lost_ff <= held_valid_ff && !has_room;
         end

         if (cmd.pick) begin
            pick_level_ff <= pick_level;
         end
      end
   end

   assign dp_status.found = found;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_ff;

endmodule

@@ rtl/core/multilevel_feedback_queue_scheduler_unit.sv @@
// top level of the multilevel feedback queue scheduler
`timescale 1ns / 1ps

// Command channel: an item is taken at a rising edge with start high and busy low.
// kind selects a task arrival or a scheduling tick; arrival fields are ignored on a tick.
// Each item yields exactly one result, shown for one cycle with rsp_valid high; the
// receiver cannot hold it off.
// Arrival: the task is written into its level's queue on the accept edge, if the
// level has room, and the result appears in the next cycle; busy stays low, so one
// arrival per cycle while no tick holds busy. Tick: the accept edge re-queues the
// previously preempted task one level down, the next cycle scans the level counts
// and reads the head entry from the queue memory, and the following cycle grants
// the slice. When nothing is queued the scan ends the tick with an idle result;
// busy is high until the result appears.
// Write time_quantum via csr_wr_en / csr_wr_data only while the block is idle; the
// block does not enforce this. Reset empties every level, drops the held task and
// sets the quantum to 2; only written entries are ever read, so no clearing is needed.
module multilevel_feedback_queue_scheduler_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mfq_pkg::req_type  req_item,
   output logic              rsp_valid,
   output mfq_pkg::rsp_type  rsp_item,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   mfq_pkg::ctl_cmd_type   cmd;
   mfq_pkg::dp_status_type dp_status;

   mfq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_item.kind),
      .dp_status(dp_status),
      .cmd      (cmd),
      .busy     (busy)
   );

   mfq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .dp_status  (dp_status),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule

@@ rtl/core/mfq_checker.sv @@
// port level checks for the scheduler, bound to the top level
`timescale 1ns / 1ps

module mfq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mfq_pkg::req_type req_item,
   input logic             rsp_valid,
   input mfq_pkg::rsp_type rsp_item,
   input logic             csr_wr_en,
   input logic [15:0]      csr_wr_data
);

   // an arrival is answered in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.kind == mfq_pkg::KIND_ARRIVAL) |=> rsp_valid)
      else $error("arrival item not answered in the next cycle");

   // a tick keeps the block busy while it picks
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.kind == mfq_pkg::KIND_TICK) |=> (busy && !rsp_valid))
      else $error("tick item did not hold busy");

   // arrival results carry nothing but status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == mfq_pkg::STATUS_ACCEPTED ||
                     rsp_item.status == mfq_pkg::STATUS_DROPPED))
      |-> (rsp_item.out_task_id == '0 && rsp_item.out_level == '0 &&
           rsp_item.slice == '0 && !rsp_item.first_run && !rsp_item.requeue_lost))
      else $error("arrival result has dispatch fields set");

   // an idle pick reports no task
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == mfq_pkg::STATUS_IDLE)
      |-> (rsp_item.out_task_id == '0 && rsp_item.out_level == '0 &&
           rsp_item.slice == '0 && !rsp_item.first_run))
      else $error("idle result has dispatch fields set");

   // a result during busy only ever ends the tick
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && busy) |-> (rsp_item.status == mfq_pkg::STATUS_IDLE))
      else $error("unexpected result while a tick is in flight");

endmodule

bind multilevel_feedback_queue_scheduler_unit mfq_checker u_checker (.*);

@@ test/tb_multilevel_feedback_queue_scheduler_unit.sv @@
// self-checking testbench for the multilevel feedback queue scheduler unit
`timescale 1ns / 1ps

module tb_multilevel_feedback_queue_scheduler_unit;
   import mfq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int DRAIN_CYCLES = 8;

   // predicts the outcome of every accepted item and checks the results in order
   class dispatch_scoreboard;
      task_type    level_slot [NUM_LEVELS][LEVEL_DEPTH];
      int          level_head [NUM_LEVELS];
      int          level_tail [NUM_LEVELS];
      int          level_fill [NUM_LEVELS];
      bit          held_valid;
      task_type    held_task;
      int          held_level;
      logic [15:0] quantum;
      rsp_type     outcome_q[$];
      int          errors;

      function new();
         for (int l = 0; l < NUM_LEVELS; l++) begin
            level_head[l] = 0;
            level_tail[l] = 0;
            level_fill[l] = 0;
         end
         held_valid = 1'b0;
         held_task  = '0;
         held_level = 0;
         quantum    = QUANTUM_RESET;
         errors     = 0;
      endfunction

      function void set_quantum(logic [15:0] q);
         quantum = q;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function bit enqueue(int lvl, task_type t);
         if (level_fill[lvl] >= LEVEL_DEPTH) return 1'b0;
         level_slot[lvl][level_tail[lvl]] = t;
         level_tail[lvl] = (level_tail[lvl] + 1) % LEVEL_DEPTH;
         level_fill[lvl]++;
         return 1'b1;
      endfunction

      function task_type dequeue(int lvl);
         task_type t;
         t = level_slot[lvl][level_head[lvl]];
         level_head[lvl] = (level_head[lvl] + 1) % LEVEL_DEPTH;
         level_fill[lvl]--;
         return t;
      endfunction

      function rsp_type schedule_outcome(req_type r);
         rsp_type  o;
         task_type t;
         int       lvl;
         int       target;
         o = '0;
         if (r.kind == KIND_ARRIVAL) begin
            lvl = (r.start_level > LAST_LEVEL_FIELD) ? NUM_LEVELS - 1 : int'(r.start_level);
            t.id = r.task_id[ID_BITS-1:0];
            t.remaining = r.run_time;
            t.started = 1'b0;
            o.status = enqueue(lvl, t) ? STATUS_ACCEPTED : STATUS_DROPPED;
         end else begin
            if (held_valid) begin
               target = (held_level + 1 > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : held_level + 1;
               if (!enqueue(target, held_task)) o.requeue_lost = 1'b1;
               held_valid = 1'b0;
            end
            lvl = NUM_LEVELS;
            for (int l = NUM_LEVELS - 1; l >= 0; l--)
               if (level_fill[l] != 0) lvl = l;
            if (lvl == NUM_LEVELS) begin
               o.status = STATUS_IDLE;
            end else begin
               t = dequeue(lvl);
               o.out_task_id = t.id;
               o.out_level = 4'(lvl);
               o.first_run = !t.started;
               if (t.remaining > quantum) begin
                  o.slice = quantum;
                  t.remaining = t.remaining - quantum;
                  t.started = 1'b1;
                  held_task = t;
                  held_level = lvl;
                  held_valid = 1'b1;
                  o.status = STATUS_PREEMPTED;
               end else begin
                  o.slice = t.remaining;
                  o.status = STATUS_FINISHED;
               end
            end
         end
         return o;
      endfunction

      function void note_item(req_type r);
         outcome_q.push_back(schedule_outcome(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (outcome_q.size() == 0) begin
            $error("unexpected result: status %0d id %0d", got.status, got.out_task_id);
            errors++;
            return;
         end
         want = outcome_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.out_task_id !== want.out_task_id) begin
            $error("out_task_id: expected %0d, got %0d", want.out_task_id, got.out_task_id);
            errors++;
         end
         if (got.out_level !== want.out_level) begin
            $error("out_level: expected %0d, got %0d", want.out_level, got.out_level);
            errors++;
         end
         if (got.slice !== want.slice) begin
            $error("slice: expected %0d, got %0d", want.slice, got.slice);
            errors++;
         end
         if (got.first_run !== want.first_run) begin
            $error("first_run: expected %0d, got %0d", want.first_run, got.first_run);
            errors++;
         end
         if (got.requeue_lost !== want.requeue_lost) begin
            $error("requeue_lost: expected %0d, got %0d", want.requeue_lost, got.requeue_lost);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   dispatch_scoreboard sb;
   bit idling_on;
   int quiet_cycles;

   multilevel_feedback_queue_scheduler_unit uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // results first, then the item taken at this edge
   always @(posedge clock) begin
      bit took;
      took = !reset && start && !busy;
      if (!reset && rsp_valid) sb.check_result(rsp_item);
      if (took) sb.note_item(req_item);
      if (reset || took || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_multilevel_feedback_queue_scheduler_unit: done, errors");
            $finish;
         end
      end
   end

   function automatic req_type make_arrival(logic [7:0] id, logic [3:0] lvl, logic [15:0] run);
      req_type r;
      r.kind = KIND_ARRIVAL;
      r.task_id = id;
      r.start_level = lvl;
      r.run_time = run;
      return r;
   endfunction

   function automatic req_type make_tick();
      req_type r;
      r = req_type'($urandom);
      r.kind = KIND_TICK;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int pick;
      r = req_type'($urandom);
      if ($urandom_range(0, 99) < 48) begin
         r.kind = KIND_TICK;
         return r;
      end
      r.kind = KIND_ARRIVAL;
      pick = $urandom_range(0, 99);
      if (pick < 25) r.start_level = 4'($urandom_range(0, 15));
      else if (pick < 60) r.start_level = 4'($urandom_range(0, 3));
      else r.start_level = 4'($urandom_range(7, 10));
      pick = $urandom_range(0, 99);
      if (pick < 3) r.run_time = '0;
      else if (pick < 50) r.run_time = 16'($urandom_range(1, 6));
      else if (pick < 85) r.run_time = 16'($urandom_range(1, 64));
      else r.run_time = 16'($urandom);
      return r;
   endfunction

   // called at a rising edge; returns at the edge that takes the item, or after a random idle gap with start low
   task automatic send_item(req_type r);
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!(start && !busy));
      if (idling_on && $urandom_range(0, 99) < 18) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0 || busy);
      @(posedge clock);
   endtask

   task automatic write_quantum(logic [15:0] q);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= q;
      sb.set_quantum(q);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [15:0] phase_quantum [6];
      int n;
      int lvl;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      quiet_cycles = 0;
      idling_on = 1'b1;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pick, then fill the last level through an out-of-range level
      send_item(make_tick());
      send_item(make_arrival(8'hFF, 4'd9, 16'hFFFF));
      for (int i = 0; i < LEVEL_DEPTH; i++)
         send_item(make_arrival(8'(i * 17), 4'hF, (i == 0) ? 16'd0 : 16'(i + 1)));
      send_item(make_arrival(8'h33, 4'd10, 16'd5));
      send_item(make_tick());
      // demotion into the full last level loses the task; zero run time dispatches
      send_item(make_tick());
      send_item(make_arrival(8'h00, 4'd0, 16'hFFFF));
      send_item(make_tick());
      write_quantum(16'd0);
      send_item(make_tick());
      send_item(make_tick());
      write_quantum(16'hFFFF);
      send_item(make_tick());

      phase_quantum[0] = 16'd1;
      phase_quantum[1] = 16'hFFFF;
      phase_quantum[2] = 16'd3;
      phase_quantum[3] = 16'($urandom_range(1, 65535));
      phase_quantum[4] = QUANTUM_RESET;
      phase_quantum[5] = 16'($urandom_range(1, 6));
      for (int p = 0; p < 6; p++) begin
         write_quantum(phase_quantum[p]);
         idling_on = (p != 2);
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 3) begin
               // burst that overflows one level
               lvl = $urandom_range(0, 10);
               for (int b = 0; b < LEVEL_DEPTH + 2; b++)
                  send_item(make_arrival(8'($urandom), 4'(lvl), 16'($urandom_range(1, 40))));
               n += LEVEL_DEPTH + 2;
            end else begin
               send_item(random_request());
               n++;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_multilevel_feedback_queue_scheduler_unit: done, clean");
      else
         $display("tb_multilevel_feedback_queue_scheduler_unit: done, errors");
      $finish;
   end

endmodule
